FILE: rtl/brn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brn_pkg: shared definitions of the bitmap rotate unit
// Types, register and mode codes, and the unsigned Q1.14 sine table.
// ----------------------------------------------------------------------------
package brn_pkg;

   localparam int STORE_DEPTH = 8192;
   localparam int STORE_AW    = 13;
   localparam int SIDE_W      = 9;
   localparam logic [SIDE_W-1:0] MAX_SIDE = 9'd256;

   // Register indexes, taken from address bit 2.
   localparam logic REG_ANGLE = 1'b0;
   localparam logic REG_SIDE  = 1'b1;

   // Request kinds carried in tuser.
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_READ = 1'b1;

   localparam logic [7:0] ANGLE_RESET = 8'd0;
   localparam logic [8:0] SIDE_RESET  = 9'd32;

   typedef struct packed {
      logic [7:0] angle;
      logic [8:0] side;
   } brn_cfg_type;

   typedef struct packed {
      logic busy;
      logic pipe_active;
   } brn_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_PIX,
      ST_DONE
   } brn_state_type;

   // sin(k*pi/128) in unsigned Q1.14 for k = 0..64.
   function automatic logic [14:0] sin_q14(input logic [6:0] k);
      logic [14:0] v;
      case (k)
         7'd0:  v = 15'd0;     7'd1:  v = 15'd402;   7'd2:  v = 15'd804;
         7'd3:  v = 15'd1205;  7'd4:  v = 15'd1606;  7'd5:  v = 15'd2006;
         7'd6:  v = 15'd2404;  7'd7:  v = 15'd2801;  7'd8:  v = 15'd3196;
         7'd9:  v = 15'd3590;  7'd10: v = 15'd3981;  7'd11: v = 15'd4370;
         7'd12: v = 15'd4756;  7'd13: v = 15'd5139;  7'd14: v = 15'd5520;
         7'd15: v = 15'd5897;  7'd16: v = 15'd6270;  7'd17: v = 15'd6639;
         7'd18: v = 15'd7005;  7'd19: v = 15'd7366;  7'd20: v = 15'd7723;
         7'd21: v = 15'd8076;  7'd22: v = 15'd8423;  7'd23: v = 15'd8765;
         7'd24: v = 15'd9102;  7'd25: v = 15'd9434;  7'd26: v = 15'd9760;
         7'd27: v = 15'd10080; 7'd28: v = 15'd10394; 7'd29: v = 15'd10702;
         7'd30: v = 15'd11003; 7'd31: v = 15'd11297; 7'd32: v = 15'd11585;
         7'd33: v = 15'd11866; 7'd34: v = 15'd12140; 7'd35: v = 15'd12406;
         7'd36: v = 15'd12665; 7'd37: v = 15'd12916; 7'd38: v = 15'd13160;
         7'd39: v = 15'd13395; 7'd40: v = 15'd13623; 7'd41: v = 15'd13842;
         7'd42: v = 15'd14053; 7'd43: v = 15'd14256; 7'd44: v = 15'd14449;
         7'd45: v = 15'd14635; 7'd46: v = 15'd14811; 7'd47: v = 15'd14978;
         7'd48: v = 15'd15137; 7'd49: v = 15'd15286; 7'd50: v = 15'd15426;
         7'd51: v = 15'd15557; 7'd52: v = 15'd15679; 7'd53: v = 15'd15791;
         7'd54: v = 15'd15893; 7'd55: v = 15'd15986; 7'd56: v = 15'd16069;
         7'd57: v = 15'd16143; 7'd58: v = 15'd16207; 7'd59: v = 15'd16261;
         7'd60: v = 15'd16305; 7'd61: v = 15'd16340; 7'd62: v = 15'd16364;
         7'd63: v = 15'd16379; 7'd64: v = 15'd16384;
         default: v = 15'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/brn_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brn_ram: generic synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module brn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

FILE: rtl/brn_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brn_csr: configuration registers
// APB-style access to the rotation angle and the bitmap side.
// ----------------------------------------------------------------------------
module brn_csr
   import brn_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output brn_cfg_type      cfg
);

   logic [7:0] angle_ff, angle_in;
   logic [8:0] side_ff, side_in;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      angle_in = angle_ff;
      side_in  = side_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            REG_ANGLE: angle_in = csr_pwdata[7:0];
            REG_SIDE:  side_in  = csr_pwdata[8:0];
            default:   angle_in = angle_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= ANGLE_RESET;
         side_ff  <= SIDE_RESET;
      end else begin
         angle_ff <= angle_in;
         side_ff  <= side_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_ANGLE: csr_prdata = {24'd0, angle_ff};
         REG_SIDE:  csr_prdata = {23'd0, side_ff};
         default:   csr_prdata = 32'd0;
      endcase
   end

   assign cfg.angle = angle_ff;
   assign cfg.side  = side_ff;

endmodule
`default_nettype wire

FILE: rtl/brn_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brn_core: request sequencer and pixel fetch pipeline
// Splits the byte position into row and column, then walks eight pixels
// through the rotate, flip and store read stages.
// ----------------------------------------------------------------------------
module brn_core
   import brn_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  brn_cfg_type              cfg,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [23:0]         req_tdata,
   input  wire logic                req_tuser,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic      [7:0]          rsp_tdata,
   output logic                     ram_we,
   output logic      [STORE_AW-1:0] ram_waddr,
   output logic      [7:0]          ram_wdata,
   output logic      [STORE_AW-1:0] ram_raddr,
   input  wire logic [7:0]          ram_rdata,
   output brn_stat_type             stat
);

   // Returns {in_range, coordinate} for a Q14 sum truncated toward zero.
   function automatic logic [8:0] coord_decode(input logic [27:0] v, input logic [8:0] side);
      logic       ok;
      logic [7:0] crd;
      if (v[27]) begin
         ok  = (&v[27:14]) && (|v[13:0]);
         crd = 8'd0;
      end else begin
         ok  = ({5'd0, side} > v[27:14]);
         crd = v[21:14];
      end
      return {ok, crd};
   endfunction

   brn_state_type state_ff, state_in;

   logic [8:0]         side_ff, side_in;
   logic [1:0]         quad_ff, quad_in;
   logic signed [15:0] cos_ff, cos_in;
   logic signed [15:0] sin_ff, sin_in;
   logic [15:0]        rem_ff, rem_in;
   logic [8:0]         row_ff, row_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic [2:0]         iss_ff, iss_in;
   logic               iss_on_ff, iss_on_in;
   logic [7:0]         res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_data_ff, rsp_data_in;

   // Pipeline stage registers.
   logic               v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic [2:0]         k1_ff, k1_in, k2_ff, k2_in, k3_ff, k3_in;
   logic               ok1_ff, ok1_in, ok2_ff, ok2_in, ok3_ff, ok3_in;
   logic signed [25:0] pxc_ff, pxc_in, pys_ff, pys_in, pyc_ff, pyc_in, pxs_ff, pxs_in;
   logic [7:0]         xs2_ff, xs2_in, ys2_ff, ys2_in;
   logic [2:0]         bit3_ff, bit3_in;

   // Request fields and configuration decode.
   logic [12:0] byte_index;
   logic [7:0]  load_data;
   logic [8:0]  side_eff;
   logic [7:0]  angle_sum;
   logic [1:0]  quad_new;
   logic [7:0]  resid;
   logic [7:0]  mag;
   logic [14:0] sin_mag;
   logic [15:0] sin_ext;

   assign byte_index = req_tdata[12:0];
   assign load_data  = req_tdata[20:13];
   assign side_eff   = (cfg.side > MAX_SIDE) ? MAX_SIDE : {cfg.side[8:1], 1'b0};
   assign angle_sum  = cfg.angle + 8'd32;
   assign quad_new   = angle_sum[7:6];
   assign resid      = cfg.angle - {quad_new, 6'd0};
   assign mag        = resid[7] ? (8'd0 - resid) : resid;
   assign sin_mag    = sin_q14(mag[6:0]);
   assign sin_ext    = {1'b0, sin_mag};

   // Divider step and range check.
   logic [7:0]  shift;
   logic [17:0] total;
   logic [16:0] dvs;
   logic        dvs_fit;
   logic [8:0]  col_next;

   assign shift    = side_ff[8:1];
   assign total    = {9'd0, side_ff} * {9'd0, side_ff};
   assign dvs      = {8'd0, side_ff} << cnt_ff;
   assign dvs_fit  = ({1'b0, rem_ff} >= dvs);
   assign col_next = {1'b0, rem_ff[7:0]} + 9'd1;

   // Stage 1: centered coordinates and the four products.
   logic        issue;
   logic signed [9:0]  x_pix, y_pix;
   logic signed [25:0] x_wide, y_wide, cos_wide, sin_wide;

   assign issue    = (state_ff == ST_PIX) && iss_on_ff;
   assign x_pix    = {2'b00, rem_ff[7:0]} - {2'b00, shift};
   assign y_pix    = {1'b0, row_ff} - {2'b00, shift};
   assign x_wide   = {{16{x_pix[9]}}, x_pix};
   assign y_wide   = {{16{y_pix[9]}}, y_pix};
   assign cos_wide = {{10{cos_ff[15]}}, cos_ff};
   assign sin_wide = {{10{sin_ff[15]}}, sin_ff};
   assign v1_in    = issue;
   assign k1_in    = iss_ff;
   assign ok1_in   = (row_ff < side_ff);
   assign pxc_in   = x_wide * cos_wide;
   assign pys_in   = y_wide * sin_wide;
   assign pyc_in   = y_wide * cos_wide;
   assign pxs_in   = x_wide * sin_wide;

   // Stage 2: rotated sums, truncation and bounds.
   logic [27:0] shift_term, sum_x, sum_y;
   logic [8:0]  dec_x, dec_y;

   assign shift_term = {6'd0, shift, 14'd0};
   assign sum_x  = {{2{pxc_ff[25]}}, pxc_ff} - {{2{pys_ff[25]}}, pys_ff} + shift_term;
   assign sum_y  = {{2{pyc_ff[25]}}, pyc_ff} + {{2{pxs_ff[25]}}, pxs_ff} + shift_term;
   assign dec_x  = coord_decode(sum_x, side_ff);
   assign dec_y  = coord_decode(sum_y, side_ff);
   assign v2_in  = v1_ff;
   assign k2_in  = k1_ff;
   assign ok2_in = ok1_ff & dec_x[8] & dec_y[8];
   assign xs2_in = dec_x[7:0];
   assign ys2_in = dec_y[7:0];

   // Stage 3: quadrant flip and store address.
   logic [7:0]  side_m1;
   logic [8:0]  side_m1_full;
   logic [7:0]  src_row, src_col;
   logic [15:0] src_pix;

   assign side_m1_full = side_ff - 9'd1;
   assign side_m1      = side_m1_full[7:0];

   always_comb begin
      case (quad_ff)
         2'd0: begin
            src_row = ys2_ff;
            src_col = xs2_ff;
         end
         2'd1: begin
            src_row = xs2_ff;
            src_col = side_m1 - ys2_ff;
         end
         2'd2: begin
            src_row = side_m1 - ys2_ff;
            src_col = side_m1 - xs2_ff;
         end
         default: begin
            src_row = side_m1 - xs2_ff;
            src_col = ys2_ff;
         end
      endcase
   end

   assign src_pix   = {8'd0, src_row} * {7'd0, side_ff} + {8'd0, src_col};
   assign ram_raddr = src_pix[15:3];
   assign v3_in     = v2_ff;
   assign k3_in     = k2_ff;
   assign ok3_in    = ok2_ff;
   assign bit3_in   = src_pix[2:0];

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      side_in      = side_ff;
      quad_in      = quad_ff;
      cos_in       = cos_ff;
      sin_in       = sin_ff;
      rem_in       = rem_ff;
      row_in       = row_ff;
      cnt_in       = cnt_ff;
      iss_in       = iss_ff;
      iss_on_in    = iss_on_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      req_tready   = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               side_in = side_eff;
               quad_in = quad_new;
               cos_in  = {1'b0, sin_q14(7'd64 - mag[6:0])};
               sin_in  = resid[7] ? (16'd0 - sin_ext) : sin_ext;
               rem_in  = {byte_index, 3'b000};
               res_in  = 8'd0;
               if (req_tuser == MODE_LOAD) begin
                  ram_we   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            // A first pixel beyond the bitmap leaves the whole byte zero.
            if ((side_ff == 9'd0) || ({2'b00, rem_ff} >= total)) begin
               state_in = ST_DONE;
            end else begin
               row_in   = 9'd0;
               cnt_in   = 3'd7;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (dvs_fit) begin
               rem_in = rem_ff - dvs[15:0];
               row_in = row_ff | (9'd1 << cnt_ff);
            end
            if (cnt_ff == 3'd0) begin
               iss_in    = 3'd0;
               iss_on_in = 1'b1;
               state_in  = ST_PIX;
            end else begin
               cnt_in = cnt_ff - 3'd1;
            end
         end
         ST_PIX: begin
            if (iss_on_ff) begin
               if (col_next == side_ff) begin
                  rem_in = 16'd0;
                  row_in = row_ff + 9'd1;
               end else begin
                  rem_in = {7'd0, col_next};
               end
               iss_in = iss_ff + 3'd1;
               if (iss_ff == 3'd7) begin
                  iss_on_in = 1'b0;
               end
            end
            if (v3_ff && (k3_ff == 3'd7)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (v3_ff) begin
         res_in[k3_ff] = ok3_ff & ram_rdata[bit3_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_on_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
      end else begin
         iss_on_ff    <= iss_on_in;
         rsp_valid_ff <= rsp_valid_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      side_ff     <= side_in;
      quad_ff     <= quad_in;
      cos_ff      <= cos_in;
      sin_ff      <= sin_in;
      rem_ff      <= rem_in;
      row_ff      <= row_in;
      cnt_ff      <= cnt_in;
      iss_ff      <= iss_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      k1_ff       <= k1_in;
      k2_ff       <= k2_in;
      k3_ff       <= k3_in;
      ok1_ff      <= ok1_in;
      ok2_ff      <= ok2_in;
      ok3_ff      <= ok3_in;
      pxc_ff      <= pxc_in;
      pys_ff      <= pys_in;
      pyc_ff      <= pyc_in;
      pxs_ff      <= pxs_in;
      xs2_ff      <= xs2_in;
      ys2_ff      <= ys2_in;
      bit3_ff     <= bit3_in;
   end

   assign ram_waddr        = byte_index;
   assign ram_wdata        = load_data;
   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tdata        = rsp_data_ff;
   assign stat.busy        = (state_ff != ST_IDLE);
   assign stat.pipe_active = v1_ff | v2_ff | v3_ff;

endmodule
`default_nettype wire

FILE: rtl/bitmap_rotate_nearest_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_rotate_nearest_unit: nearest neighbor rotation of a 1-bit bitmap
// Stores a square packed bitmap and returns bytes of its rotated image.
// ----------------------------------------------------------------------------
// The request channel carries one request per handshake. A load request
// (tuser low) writes a source byte into the 8192 x 8 store; a read request
// (tuser high) returns one byte of the bitmap rotated by the configured angle.
// Every request yields exactly one response; a load responds with zero.
// A load goes straight to the output register. A read whose first pixel lies
// inside the bitmap passes through one range check, eight steps of the divider
// that splits the byte position into row and column, eight pixel issues (the
// store has one read port, so one source pixel per cycle), the three stage
// drain of the rotate, flip and fetch pipeline and the output register. A read
// beyond the bitmap goes from the range check to the output register. One
// request is in work at a time; the next one is accepted once the previous
// result sits in the output register.
// If the receiver stalls, the result holds in the output register while the
// next request is already taken and worked on, and that one waits for the
// register to drain. Reset clears the sequencer and sets the angle to 0 and the
// side to 32; the store contents are undefined until loaded. Configuration is to
// be written only while no request is in work; the block does not enforce it.
// ----------------------------------------------------------------------------
module bitmap_rotate_nearest_unit
   import brn_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [12:0] byte_index, [20:13] load_data, rest zero
   input  wire logic        req_tuser,   // [0] mode: 0 load, 1 read
   // Response channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [7:0]  rsp_tdata,   // [7:0] read_data
   // Configuration port.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   brn_cfg_type             cfg;
   brn_stat_type            stat;
   logic                    ram_we;
   logic [STORE_AW-1:0]     ram_waddr;
   logic [7:0]              ram_wdata;
   logic [STORE_AW-1:0]     ram_raddr;
   logic [7:0]              ram_rdata;

   brn_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The source store: written by loads, read one pixel per cycle by reads.
   brn_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   brn_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .stat       (stat)
   );

   // An accepted request always occupies the sequencer for the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while the previous one was still in work");

   // The store is written only by an accepted load request.
   a_write_only_on_load: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (req_tvalid && req_tready && (req_tuser == MODE_LOAD)))
      else $error("store written without an accepted load");

   // The pixel pipeline runs only while a read is in work.
   a_pipe_while_busy: assert property (@(posedge clock) disable iff (reset)
      stat.pipe_active |-> (stat.busy && !req_tready))
      else $error("pixel pipeline active while the unit is idle");

endmodule
`default_nettype wire
